/* hdl/hmtq_pkg.sv */
// Shared types, constants and state codes for the height map triangle height query block.
// No dependencies; the queue, both ends, the top level, the checker and the bench import this package.
package hmtq_pkg;

   localparam int HEIGHT_BITS     = 16;
   localparam int COORD_FRAC_BITS = 8;
   localparam int POS_W           = 16 + COORD_FRAC_BITS;
   localparam int SIZE_W          = 16;
   localparam int DIM_W           = 9;
   localparam int IDX_W           = 12;
   localparam int CSR_IDX_W       = 2;
   localparam int PROD_W          = HEIGHT_BITS + 18;
   localparam int NUM_W           = HEIGHT_BITS + 19;
   localparam int DIV_STEP        = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 2'd2;

   localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = 16'd256;
   localparam logic [DIM_W-1:0]  GRID_DIM_RESET  = 9'd256;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [7:0]                grid_col;
      logic [7:0]                grid_row;
      logic signed [HEIGHT_BITS-1:0] height_in;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_z;
   } req_type;

   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] height_out;
      logic                      out_of_range;
   } rsp_type;

   // Entry passed from the front end to the back end.
   typedef struct packed {
      logic                      kind;
      logic                      flag;
      logic                      lower;
      logic [IDX_W-1:0]          col;
      logic [IDX_W-1:0]          row;
      logic [SIZE_W-1:0]         offx;
      logic [SIZE_W-1:0]         offz;
      logic signed [HEIGHT_BITS-1:0] height;
   } qent_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_RD1,
      B_RD2,
      B_RD3,
      B_MA,
      B_MB,
      B_MC,
      B_MD,
      B_DIV,
      B_WAIT,
      B_OUT
   } back_state_type;

endpackage

/* hdl/hmtq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hmtq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/hmtq_div.sv */
// Iterative unsigned divider, STEP quotient bits per cycle.
// No dependencies.
module hmtq_div #(
   parameter int DW   = 24,
   parameter int VW   = 16,
   parameter int STEP = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int NSTEP = (DW + STEP - 1) / STEP;
   localparam int PW    = NSTEP * STEP;
   localparam int CW    = $clog2(NSTEP + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] div_ff, div_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [VW:0]   r;
   logic [PW-1:0] q;

   // Restoring division, several bits per cycle.
   always_comb begin
      r = {1'b0, rem_ff};
      q = quo_ff;
      for (int i = 0; i < STEP; i++) begin
         r = {r[VW-1:0], q[PW-1]};
         q = {q[PW-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r    = r - {1'b0, div_ff};
            q[0] = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NSTEP);
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = PW'(dividend);
      end else if (busy_ff) begin
         rem_in = r[VW-1:0];
         quo_in = q;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[DW-1:0];
   assign remainder = rem_ff;

endmodule

/* hdl/hmtq_queue.sv */
// Small flip-flop queue of front-to-back entries.
// Depends on hmtq_pkg.
module hmtq_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hmtq_pkg::qent_type wr_data,
   output logic              full,
   input  logic              pop,
   output hmtq_pkg::qent_type rd_data,
   output logic              empty
);
   import hmtq_pkg::*;

   localparam int PW  = $clog2(DEPTH);
   localparam int CNW = $clog2(DEPTH + 1);

   qent_type       mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hdl/hmtq_front.sv */
// Front end: accepts items, splits query coordinates into cell and offset.
// Depends on hmtq_pkg and hmtq_div.
module hmtq_front #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  hmtq_pkg::req_type            req_data,
   input  logic [hmtq_pkg::SIZE_W-1:0]  cell_size,
   input  logic [hmtq_pkg::DIM_W-1:0]   grid_columns,
   input  logic [hmtq_pkg::DIM_W-1:0]   grid_rows,
   output logic                         q_push,
   output hmtq_pkg::qent_type           q_data,
   input  logic                         q_full
);
   import hmtq_pkg::*;

   front_state_type state_ff, state_in;

   logic              accept;
   logic              special;
   logic              div_start;
   logic              done_x;
   logic signed [POS_W:0] zn_full;
   logic [POS_W-1:0]  quo_x, quo_z;
   logic [SIZE_W-1:0] rem_x, rem_z;
   logic [POS_W:0]    col_p1, row_p1;
   logic              oob;
   logic              lower;

   assign req_full = (state_ff != F_IDLE) || q_full;
   assign accept   = req_push && !req_full;
   assign zn_full  = -$signed({req_data.pos_z[POS_W-1], req_data.pos_z});
   assign special  = (cell_size == '0) || req_data.pos_x[POS_W-1] || zn_full[POS_W];

   hmtq_div #(.DW(POS_W), .VW(SIZE_W), .STEP(DIV_STEP)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_data.pos_x),
      .divisor   (cell_size),
      .done      (done_x),
      .quotient  (quo_x),
      .remainder (rem_x)
   );

   hmtq_div #(.DW(POS_W), .VW(SIZE_W), .STEP(DIV_STEP)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (zn_full[POS_W-1:0]),
      .divisor   (cell_size),
      .done      (),
      .quotient  (quo_z),
      .remainder (rem_z)
   );

   assign col_p1 = {1'b0, quo_x} + (POS_W + 1)'(1);
   assign row_p1 = {1'b0, quo_z} + (POS_W + 1)'(1);
   assign oob    = (col_p1 >= (POS_W + 1)'(grid_columns)) ||
                   (row_p1 >= (POS_W + 1)'(grid_rows)) ||
                   (col_p1 >= (POS_W + 1)'(MAX_COLS)) ||
                   (row_p1 >= (POS_W + 1)'(MAX_ROWS));
   assign lower  = ({1'b0, rem_x} + {1'b0, rem_z}) <= {1'b0, cell_size};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept && (req_data.kind == KIND_QUERY) && !special) begin
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (done_x) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      q_push    = 1'b0;
      q_data    = '0;
      div_start = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept && (req_data.kind == KIND_WRITE)) begin
               q_data.kind   = KIND_WRITE;
               q_data.col    = IDX_W'(req_data.grid_col);
               q_data.row    = IDX_W'(req_data.grid_row);
               q_data.height = req_data.height_in;
               q_push = (32'(req_data.grid_col) < MAX_COLS) &&
                        (32'(req_data.grid_row) < MAX_ROWS);
            end else if (accept) begin
               q_data.kind = KIND_QUERY;
               q_data.flag = 1'b1;
               q_push      = special;
               div_start   = !special;
            end
         end
         F_PUSH: begin
            q_push       = !q_full;
            q_data.kind  = KIND_QUERY;
            q_data.flag  = oob;
            q_data.lower = lower;
            q_data.col   = quo_x[IDX_W-1:0];
            q_data.row   = quo_z[IDX_W-1:0];
            q_data.offx  = rem_x;
            q_data.offz  = rem_z;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/hmtq_back.sv */
// Back end: writes samples, reads three corners, interpolates and divides.
// Depends on hmtq_pkg, hmtq_ram and hmtq_div.
module hmtq_back #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  hmtq_pkg::qent_type          q_data,
   output logic                        q_pop,
   input  logic [hmtq_pkg::SIZE_W-1:0] cell_size,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output hmtq_pkg::rsp_type           rsp_data
);
   import hmtq_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [NUM_W-1:0] POS_LIM = NUM_W'((64'd1 << (HEIGHT_BITS - 1)) - 64'd1);
   localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(64'd1 << (HEIGHT_BITS - 1));

   back_state_type state_ff, state_in;

   qent_type                   ent_ff, ent_in;
   logic signed [HEIGHT_BITS-1:0] h10_ff, h10_in, h01_ff, h01_in, hc_ff, hc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [NUM_W-1:0]    acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       pop_ok, slot_free;
   logic                       load_rsp;
   rsp_type                    load_data;
   logic                       ram_we;
   logic [AW-1:0]              head_base, ent_base, ram_raddr;
   logic [HEIGHT_BITS-1:0]     ram_rdata;
   logic signed [HEIGHT_BITS:0] mul_a;
   logic signed [SIZE_W:0]     mul_b;
   logic signed [HEIGHT_BITS:0] h_a, h_b;
   logic [SIZE_W-1:0]          w_a, w_b;
   logic                       div_start, div_done;
   logic [NUM_W-1:0]           dividend, quo, quo_neg;
   logic signed [HEIGHT_BITS-1:0] result;

   assign pop_ok    = rsp_pop && rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || pop_ok;
   assign head_base = AW'(q_data.col) * AW'(MAX_ROWS) + AW'(q_data.row);
   assign ent_base  = AW'(ent_ff.col) * AW'(MAX_ROWS) + AW'(ent_ff.row);

   hmtq_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_base),
      .wr_data (q_data.height),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Corner weights: the lower triangle anchors on (col,row), the upper on
   // (col+1,row+1) with weights measured from the far edges.
   assign h_a = ent_ff.lower ? HEIGHT_BITS'(h10_ff) - hc_ff : h01_ff - hc_ff;
   assign h_b = ent_ff.lower ? h01_ff - hc_ff : h10_ff - hc_ff;
   assign w_a = ent_ff.lower ? ent_ff.offx : cell_size - ent_ff.offx;
   assign w_b = ent_ff.lower ? ent_ff.offz : cell_size - ent_ff.offz;

   // Floor division of a signed sum by a positive divisor via the magnitude.
   assign dividend = acc_ff[NUM_W-1] ?
                     NUM_W'(-acc_ff) + NUM_W'(cell_size) - NUM_W'(1) :
                     NUM_W'(acc_ff);

   hmtq_div #(.DW(NUM_W), .VW(SIZE_W), .STEP(DIV_STEP)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (cell_size),
      .done      (div_done),
      .quotient  (quo),
      .remainder ()
   );

   assign quo_neg = NUM_W'(0) - quo;

   always_comb begin
      if (!neg_ff) begin
         result = (quo > POS_LIM) ? POS_LIM[HEIGHT_BITS-1:0] : quo[HEIGHT_BITS-1:0];
      end else begin
         result = (quo > NEG_LIM) ? NEG_LIM[HEIGHT_BITS-1:0] : quo_neg[HEIGHT_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty && (q_data.kind == KIND_QUERY) && !q_data.flag) begin
               state_in = B_RD1;
            end
         end
         B_RD1:  state_in = B_RD2;
         B_RD2:  state_in = B_RD3;
         B_RD3:  state_in = B_MA;
         B_MA:   state_in = B_MB;
         B_MB:   state_in = B_MC;
         B_MC:   state_in = B_MD;
         B_MD:   state_in = B_DIV;
         B_DIV:  state_in = B_WAIT;
         B_WAIT: begin
            if (div_done) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (slot_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_raddr = ent_base;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      load_data = '0;
      case (state_ff)
         B_IDLE: begin
            ram_raddr = head_base + AW'(MAX_ROWS);
            if (!q_empty) begin
               if (q_data.kind == KIND_WRITE) begin
                  q_pop  = 1'b1;
                  ram_we = 1'b1;
               end else if (q_data.flag) begin
                  q_pop                  = slot_free;
                  load_rsp               = slot_free;
                  load_data.out_of_range = 1'b1;
               end else begin
                  q_pop = 1'b1;
               end
            end
         end
         B_RD1: ram_raddr = ent_base + AW'(1);
         B_RD2: ram_raddr = ent_ff.lower ? ent_base : ent_base + AW'(MAX_ROWS + 1);
         B_MA: begin
            mul_a = (HEIGHT_BITS + 1)'(hc_ff);
            mul_b = {1'b0, cell_size};
         end
         B_MB: begin
            mul_a = h_a;
            mul_b = {1'b0, w_a};
         end
         B_MC: begin
            mul_a = h_b;
            mul_b = {1'b0, w_b};
         end
         B_DIV: div_start = 1'b1;
         B_OUT: begin
            load_rsp             = slot_free;
            load_data.height_out = result;
         end
         default: begin
            ram_raddr = ent_base;
         end
      endcase
   end

   always_comb begin
      ent_in  = (q_pop && (state_ff == B_IDLE)) ? q_data : ent_ff;
      h10_in  = (state_ff == B_RD1) ? $signed(ram_rdata) : h10_ff;
      h01_in  = (state_ff == B_RD2) ? $signed(ram_rdata) : h01_ff;
      hc_in   = (state_ff == B_RD3) ? $signed(ram_rdata) : hc_ff;
      prod_in = mul_a * mul_b;
      acc_in  = acc_ff;
      if (state_ff == B_MB) begin
         acc_in = NUM_W'(prod_ff);
      end else if ((state_ff == B_MC) || (state_ff == B_MD)) begin
         acc_in = acc_ff + NUM_W'(prod_ff);
      end
      neg_in       = (state_ff == B_DIV) ? acc_ff[NUM_W-1] : neg_ff;
      rsp_in       = load_rsp ? load_data : rsp_ff;
      rsp_valid_in = load_rsp ? 1'b1 : (pop_ok ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      h10_ff  <= h10_in;
      h01_ff  <= h01_in;
      hc_ff   <= hc_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/heightmap_triangle_height_query.sv */
// Top level of the height map triangle height query block.
// Depends on hmtq_pkg, hmtq_front, hmtq_queue and hmtq_back.

// The block stores a grid of signed Q8.8 height samples and answers height
// queries on it. A write item (kind 0) stores one sample at (grid_col,
// grid_row) and gives no result; writes outside the store are dropped. A query
// item (kind 1) gives exactly one result: the height on the chosen triangle of
// the cell under (pos_x, -pos_z), floored and saturated, or zero with
// out_of_range set when the cell's corners fall outside the grid, the
// coordinate is negative, or the cell size is zero. A query passes through the
// front end, which accepts it, lets two dividers split the coordinates by the
// cell size four quotient bits a cycle, and pushes it into the queue. The back
// end then makes three corner reads from the single read port of the sample
// memory, forms three products on one shared multiplier, and divides the
// weighted sum. The back end takes no new query until the last one's result is
// out, and so sets the sustained query rate; the queue between the two ends
// lets writes and the next query's coordinate split run ahead. Samples must be
// written before any query reads them, since the memory is not cleared. The
// user must write configuration registers only while the block is idle; the
// block itself does not enforce this. Every configuration transfer completes
// in the cycle it is offered.
module heightmap_triangle_height_query #(
   parameter int MAX_COLS    = 256,
   parameter int MAX_ROWS    = 256,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  hmtq_pkg::req_type              req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output hmtq_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hmtq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hmtq_pkg::SIZE_W-1:0]    csr_wdata
);
   import hmtq_pkg::*;

   logic [SIZE_W-1:0] cell_size_ff, cell_size_in;
   logic [DIM_W-1:0]  grid_columns_ff, grid_columns_in;
   logic [DIM_W-1:0]  grid_rows_ff, grid_rows_in;

   logic     q_push, q_full, q_pop, q_empty;
   qent_type q_wr_data, q_rd_data;

   // The configuration channel never stalls. Writes to unknown indexes are
   // accepted and have no effect.
   assign csr_ready = 1'b1;

   always_comb begin
      cell_size_in    = cell_size_ff;
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CELL_SIZE:    cell_size_in    = csr_wdata;
            CSR_GRID_COLUMNS: grid_columns_in = csr_wdata[DIM_W-1:0];
            CSR_GRID_ROWS:    grid_rows_in    = csr_wdata[DIM_W-1:0];
            default:          cell_size_in    = cell_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff    <= CELL_SIZE_RESET;
         grid_columns_ff <= GRID_DIM_RESET;
         grid_rows_ff    <= GRID_DIM_RESET;
      end else begin
         cell_size_ff    <= cell_size_in;
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
      end
   end

   // Front end: takes items, classifies them and splits query coordinates.
   hmtq_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .cell_size    (cell_size_ff),
      .grid_columns (grid_columns_ff),
      .grid_rows    (grid_rows_ff),
      .q_push       (q_push),
      .q_data       (q_wr_data),
      .q_full       (q_full)
   );

   // Short queue so that each end stalls on its own.
   hmtq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // Back end: owns the sample memory, so writes and reads stay in order.
   hmtq_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .cell_size (cell_size_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/hmtq_checker.sv */
// Port-level checks of the height map triangle height query block, bound to the top level.
// Depends on hmtq_pkg and heightmap_triangle_height_query.
module hmtq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_push,
   input logic                           req_full,
   input hmtq_pkg::req_type              req_data,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input hmtq_pkg::rsp_type              rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [hmtq_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [hmtq_pkg::SIZE_W-1:0]    csr_wdata
);
   import hmtq_pkg::*;

   // No result is left over from before a reset.
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result present right after reset");

   // A flagged query always reports a zero height.
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_of_range) |-> (rsp_data.height_out == '0))
      else $error("flagged result with nonzero height");

   // A waiting result stays until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   // A configuration write is never stalled.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration transfer stalled");

endmodule

bind heightmap_triangle_height_query hmtq_checker u_hmtq_checker (.*);

/* bench/heightmap_triangle_height_query_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for heightmap_triangle_height_query: writes height samples, queries heights
// under several grid settings and compares every result. Depends on hmtq_pkg and heightmap_triangle_height_query.

module heightmap_triangle_height_query_test;
   import hmtq_pkg::*;

   // Cycles without any transfer before the run is declared hung. The limit leaves a wide
   // margin over a query's way through the block and over the longest receiver stall and
   // sender gap.
   localparam int HANG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_ITEMS = 1800;

   // Terrain model: its own copy of the sample store and the three registers, and a queue
   // of the heights the block still owes us, oldest first.
   class terrain_scoreboard;
      logic signed [HEIGHT_BITS-1:0] samples [65536];
      longint cell_len;
      longint cols;
      longint rows;
      rsp_type owed[$];
      int errors;
      int checked;
      int flagged;

      function new();
         cell_len = CELL_SIZE_RESET;
         cols = GRID_DIM_RESET;
         rows = GRID_DIM_RESET;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
         case (idx)
            CSR_CELL_SIZE: begin
               cell_len = value;
            end
            CSR_GRID_COLUMNS: begin
               cols = value[DIM_W-1:0];
            end
            CSR_GRID_ROWS: begin
               rows = value[DIM_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Height on the triangle under (x, -z), with the quotient rounded toward minus
      // infinity and the result clamped to the sample range.
      function rsp_type interpolate(logic signed [POS_W-1:0] pos_x,
                                    logic signed [POS_W-1:0] pos_z);
         rsp_type r;
         longint x, zn, col, row, offx, offz, num, q, h00, h10, h01, h11;
         x = pos_x;
         zn = -longint'(pos_z);
         r.height_out = '0;
         r.out_of_range = 1'b1;
         if (cell_len == 0 || x < 0 || zn < 0) return r;
         col = x / cell_len;
         row = zn / cell_len;
         offx = x % cell_len;
         offz = zn % cell_len;
         if (col + 1 >= cols || row + 1 >= rows || col + 1 >= 256 || row + 1 >= 256)
            return r;
         h10 = samples[(col + 1) * 256 + row];
         h01 = samples[col * 256 + row + 1];
         if (offx + offz <= cell_len) begin
            h00 = samples[col * 256 + row];
            num = h00 * cell_len + (h10 - h00) * offx + (h01 - h00) * offz;
         end else begin
            h11 = samples[(col + 1) * 256 + row + 1];
            num = h11 * cell_len + (h01 - h11) * (cell_len - offx) +
                  (h10 - h11) * (cell_len - offz);
         end
         q = num / cell_len;
         if (num % cell_len != 0 && num < 0) q = q - 1;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         r.height_out = q[HEIGHT_BITS-1:0];
         r.out_of_range = 1'b0;
         return r;
      endfunction

      function void note_request(req_type req);
         if (req.kind == KIND_WRITE)
            samples[{req.grid_col, req.grid_row}] = req.height_in;
         else
            owed.push_back(interpolate(req.pos_x, req.pos_z));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result: height %0d flag %0b",
                                       got.height_out, got.out_of_range);
            return;
         end
         want = owed.pop_front();
         checked++;
         if (want.out_of_range) flagged++;
         if (got.height_out !== want.height_out || got.out_of_range !== want.out_of_range)
         begin
            errors++;
            if (errors <= 10)
               $display("Mismatch: expected height %0d flag %0b, got height %0d flag %0b",
                        want.height_out, want.out_of_range, got.height_out, got.out_of_range);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CELL_SIZE;
   logic [SIZE_W-1:0] csr_wdata = '0;

   terrain_scoreboard board = new();
   bit written [65536];
   int quiet_items;
   int hang_count;
   int rsp_stall;
   int writes_sent;
   int queries_sent;
   int config_writes;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   heightmap_triangle_height_query i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Mostly no gap, often a short one, now and then a long one. After a random
   // trigger a stretch of items runs with no gaps at all.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_items > 0) begin
         quiet_items--;
         return 0;
      end
      if (roll == 0) quiet_items = $urandom_range(20, 60);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The result side pops with its own random stalls: in most cycles it pops at random, and
   // now and then it holds off for a long stretch; every transfer is checked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            board.check_response(rsp_data);
            hang_count = 0;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_stall = $urandom_range(10, 40);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) < 75);
         end
      end
   end

   // Watchdog: the run ends if nothing moves for too long.
   always @(posedge clock) begin
      hang_count++;
      if (hang_count >= HANG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", HANG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one item and holds it until the block takes it. Push is dropped only when
   // a gap follows, so it is never lowered and raised in the same step.
   task automatic send_item(req_type item);
      int gap;
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      board.note_request(item);
      hang_count = 0;
      if (item.kind == KIND_WRITE) begin
         written[{item.grid_col, item.grid_row}] = 1'b1;
         writes_sent++;
      end else begin
         queries_sent++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_write(logic [7:0] col, logic [7:0] row, logic signed [15:0] h);
      req_type item;
      item = '0;
      item.kind = KIND_WRITE;
      item.grid_col = col;
      item.grid_row = row;
      item.height_in = h;
      item.pos_x = POS_W'($urandom);
      item.pos_z = POS_W'($urandom);
      send_write_item(item);
   endtask

   task automatic send_write_item(req_type item);
      send_item(item);
   endtask

   // Sends a query; if it would read corners that were never written, those corners
   // get random samples first so no undefined entry is ever read.
   task automatic send_query(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz);
      req_type item;
      longint x, zn, col, row;
      x = px;
      zn = -longint'(pz);
      if (board.cell_len != 0 && x >= 0 && zn >= 0) begin
         col = x / board.cell_len;
         row = zn / board.cell_len;
         if (col + 1 < board.cols && row + 1 < board.rows && col + 1 < 256 && row + 1 < 256)
            for (int dc = 0; dc < 2; dc++)
               for (int dr = 0; dr < 2; dr++)
                  if (!written[(col + dc) * 256 + row + dr])
                     send_write(8'(col + dc), 8'(row + dr), 16'($urandom));
      end
      item = '0;
      item.kind = KIND_QUERY;
      item.grid_col = 8'($urandom);
      item.grid_row = 8'($urandom);
      item.height_in = HEIGHT_BITS'($urandom);
      item.pos_x = px;
      item.pos_z = pz;
      send_item(item);
   endtask

   // A query inside the grid: random cell, offsets often on the cell edges or on the
   // diagonal between the two triangles.
   task automatic send_inside_query();
      longint s, maxc, maxr, col, row, offx, offz;
      s = board.cell_len;
      maxc = (8388607 - (s - 1)) / s;
      if (maxc > board.cols - 2) maxc = board.cols - 2;
      maxr = (8388607 - (s - 1)) / s;
      if (maxr > board.rows - 2) maxr = board.rows - 2;
      col = $urandom_range(0, maxc);
      row = $urandom_range(0, maxr);
      case ($urandom_range(0, 3))
         0: offx = 0;
         1: offx = s - 1;
         default: offx = $urandom_range(0, s - 1);
      endcase
      case ($urandom_range(0, 4))
         0: offz = 0;
         1: offz = s - 1;
         2: offz = s - offx;
         default: offz = $urandom_range(0, s - 1);
      endcase
      if (offz >= s) offz = s - 1;
      send_query(POS_W'(col * s + offx), POS_W'(-(row * s + offz)));
   endtask

   // Registers change only with the block idle: no result owed, and enough extra
   // cycles for any trailing write to finish.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      hang_count = 0;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, value);
      config_writes++;
      hang_count = 0;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [SIZE_W-1:0] s, logic [SIZE_W-1:0] c, logic [SIZE_W-1:0] r);
      wait_idle();
      write_register(CSR_CELL_SIZE, s);
      write_register(CSR_GRID_COLUMNS, c);
      write_register(CSR_GRID_ROWS, r);
   endtask

   // Random traffic: mostly well-formed queries inside the grid, plus stray writes
   // anywhere in the store and queries at arbitrary coordinates. The count covers the
   // corner writes that queries send ahead of themselves.
   task automatic random_phase(int count);
      int roll;
      int target;
      target = writes_sent + queries_sent + count;
      while (writes_sent + queries_sent < target) begin
         roll = $urandom_range(0, 99);
         if (board.cell_len != 0 && roll < 60)
            send_inside_query();
         else if (roll < 80)
            send_write(8'($urandom), 8'($urandom), 16'($urandom));
         else
            send_query(POS_W'($urandom), POS_W'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings: extreme samples, exact corners, the
      // diagonal, both triangles, negative coordinates and far-out positions.
      configure(16'd256, 16'd256, 16'd256);
      send_write(8'd0, 8'd0, 16'sh7fff);
      send_write(8'd1, 8'd0, 16'sh8000);
      send_write(8'd0, 8'd1, 16'sh8000);
      send_write(8'd1, 8'd1, 16'sh7fff);
      send_write(8'd255, 8'd255, 16'sh0001);
      send_query(24'sd0, 24'sd0);
      send_query(24'sd128, -24'sd128);
      send_query(24'sd255, -24'sd255);
      send_query(24'sd255, -24'sd1);
      send_query(24'sd1, -24'sd255);
      send_query(24'sd256, -24'sd0);
      send_query(-24'sd1, -24'sd10);
      send_query(24'sd10, 24'sd1);
      send_query(24'sh7fffff, 24'sh800000);
      send_query(24'sh800000, 24'sh7fffff);
      send_query(24'sd65279, -24'sd65279);
      send_query(24'sd65280, -24'sd10);
      send_query(24'sd10, -24'sd65280);

      // Smallest grid and cell.
      configure(16'd1, 16'd2, 16'd2);
      send_query(24'sd0, 24'sd0);
      send_query(24'sd1, -24'sd0);
      random_phase(RANDOM_ITEMS / 6);

      // Largest cell on the full grid.
      configure(16'hffff, 16'd256, 16'd256);
      random_phase(RANDOM_ITEMS / 6);

      // Zero cell size: every query is flagged.
      configure(16'd0, 16'd256, 16'd256);
      random_phase(40);

      // Several random mid-range settings.
      for (int p = 0; p < 4; p++) begin
         configure(SIZE_W'($urandom_range(1, 4000)), SIZE_W'($urandom_range(2, 256)),
                   SIZE_W'($urandom_range(2, 256)));
         random_phase(RANDOM_ITEMS / 6);
      end

      wait_idle();
      $display("Covered %0d writes and %0d queries (%0d flagged) over %0d register writes.",
               writes_sent, queries_sent, board.flagged, config_writes);
      $display("Checked %0d results, %0d mismatches.", board.checked, board.errors);
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
